// ===== design/jeop_pkg.sv =====
// Package: shared types, marker codes and register indexes for the Exif tag parser.
`timescale 1ns / 1ps
package jeop_pkg;

  typedef enum logic [3:0] {
    PH_SOI,
    PH_MARKER,
    PH_LEN,
    PH_SKIPSEG,
    PH_EXIFHDR,
    PH_ORDER,
    PH_MAGIC,
    PH_OFFSET,
    PH_SKIPIFD,
    PH_COUNT,
    PH_ENTRY,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] value;
    logic        found;
  } result_t;

  localparam logic [7:0]  MARKER_PREFIX = 8'hFF;
  localparam logic [7:0]  SOI_CODE      = 8'hD8;
  localparam logic [7:0]  EOI_CODE      = 8'hD9;
  localparam logic [7:0]  SOS_CODE      = 8'hDA;
  localparam logic [15:0] APP1_CODE     = 16'h00E1;
  localparam logic [31:0] ORDER_II      = 32'h0000_4949;
  localparam logic [31:0] ORDER_MM      = 32'h0000_4D4D;
  localparam logic [15:0] TIFF_MAGIC    = 16'd42;
  localparam logic [15:0] SEG_LEN_MIN   = 16'd2;
  localparam logic [15:0] EXIF_LEN_MIN  = 16'd8;
  localparam logic [31:0] IFD_OFS_MIN   = 32'd8;
  localparam logic [3:0]  EXIF_SIG_LAST = 4'd5;
  localparam logic [3:0]  OFFSET_LAST   = 4'd3;
  localparam logic [3:0]  ENTRY_TAG_IDX = 4'd1;
  localparam logic [3:0]  ENTRY_VAL_IDX = 4'd9;
  localparam logic [3:0]  ENTRY_LAST    = 4'd11;

  localparam logic [15:0] TARGET_TAG_RESET    = 16'h0112;
  localparam logic [15:0] DEFAULT_VALUE_RESET = 16'd1;

  localparam logic CFG_TARGET_TAG    = 1'b0;
  localparam logic CFG_DEFAULT_VALUE = 1'b1;

  // "Exif\0\0" signature byte by position
  function automatic logic [7:0] exif_sig(input logic [2:0] idx);
    logic [7:0] s;
    unique case (idx)
      3'd0:    s = 8'h45;
      3'd1:    s = 8'h78;
      3'd2:    s = 8'h69;
      3'd3:    s = 8'h66;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== design/jeop_in_reg.sv =====
// Input register stage: captures one byte transfer and holds it until the parser takes it.
`timescale 1ns / 1ps
module jeop_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  jeop_pkg::item_t item_in,
  input  logic          advance,
  output logic          item_valid,
  output jeop_pkg::item_t item_q
);
  import jeop_pkg::*;

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_q <= item_in;
    end
  end

endmodule

// ===== design/jeop_parser.sv =====
// Parser state and single-byte next-state logic for the JPEG/Exif tag walk.
`timescale 1ns / 1ps
module jeop_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  jeop_pkg::item_t  item,
  input  logic [15:0]      target_tag,
  input  logic [15:0]      default_value,
  output jeop_pkg::result_t res
);
  import jeop_pkg::*;

  phase_t      phase, phase_next;
  logic [3:0]  field_byte_index, field_byte_index_next;
  logic [31:0] assembly, assembly_next;
  logic [31:0] skip_remaining, skip_remaining_next;
  logic [15:0] segment_length, segment_length_next;
  logic        little_endian, little_endian_next;
  logic [15:0] entries_left, entries_left_next;
  logic [15:0] current_tag, current_tag_next;
  logic        result_given, result_given_next;

  logic [7:0]  b;
  logic [31:0] asm_sh;
  logic [15:0] o16;
  logic [31:0] off32;
  logic [31:0] skip_dec;
  logic        mism;
  logic        emit;
  logic [15:0] emit_value;
  logic        emit_found;

  assign b        = item.data;
  assign asm_sh   = {assembly[23:0], b};
  assign o16      = little_endian ? {asm_sh[7:0], asm_sh[15:8]} : asm_sh[15:0];
  assign off32    = little_endian ? {asm_sh[7:0], asm_sh[15:8], asm_sh[23:16], asm_sh[31:24]}
                                  : asm_sh;
  assign skip_dec = skip_remaining - 32'd1;
  assign mism     = assembly[0] | (b != exif_sig(field_byte_index[2:0]));

  always_comb begin
    phase_next            = phase;
    field_byte_index_next = field_byte_index;
    assembly_next         = assembly;
    skip_remaining_next   = skip_remaining;
    segment_length_next   = segment_length;
    little_endian_next    = little_endian;
    entries_left_next     = entries_left;
    current_tag_next      = current_tag;
    result_given_next     = result_given;
    emit                  = 1'b0;
    emit_value            = default_value;
    emit_found            = 1'b0;
    res                   = '0;

    if (step && !result_given) begin
      assembly_next = asm_sh;
      unique case (phase)
        PH_SOI: begin
          if ((field_byte_index == 4'd0 && b != MARKER_PREFIX) ||
              (field_byte_index == 4'd1 && b != SOI_CODE)) begin
            emit = 1'b1;
          end else if (field_byte_index == 4'd1) begin
            phase_next = PH_MARKER; field_byte_index_next = '0; assembly_next = '0;
          end else begin
            field_byte_index_next = 4'd1;
          end
        end
        PH_MARKER: begin
          if (field_byte_index == 4'd0) begin
            if (b != MARKER_PREFIX) emit = 1'b1;
            else field_byte_index_next = 4'd1;
          end else if (b == EOI_CODE || b == SOS_CODE) begin
            emit = 1'b1;
          end else begin
            current_tag_next = {8'h00, b};
            phase_next = PH_LEN; field_byte_index_next = '0; assembly_next = '0;
          end
        end
        PH_LEN: begin
          if (field_byte_index == 4'd0) begin
            field_byte_index_next = 4'd1;
          end else begin
            segment_length_next = asm_sh[15:0];
            if (current_tag == APP1_CODE) begin
              phase_next = PH_EXIFHDR; field_byte_index_next = '0; assembly_next = '0;
            end else if (asm_sh[15:0] < SEG_LEN_MIN) begin
              emit = 1'b1;
            end else begin
              skip_remaining_next = {16'h0000, asm_sh[15:0] - SEG_LEN_MIN};
              phase_next = (asm_sh[15:0] == SEG_LEN_MIN) ? PH_MARKER : PH_SKIPSEG;
              field_byte_index_next = '0; assembly_next = '0;
            end
          end
        end
        PH_SKIPSEG: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_MARKER; field_byte_index_next = '0; assembly_next = '0;
          end
        end
        PH_EXIFHDR: begin
          // hold only the running mismatch flag
          assembly_next = {31'd0, mism};
          if (field_byte_index < EXIF_SIG_LAST) begin
            field_byte_index_next = field_byte_index + 4'd1;
          end else if (!mism) begin
            phase_next = PH_ORDER; field_byte_index_next = '0; assembly_next = '0;
          end else if (segment_length < EXIF_LEN_MIN) begin
            emit = 1'b1;
          end else begin
            skip_remaining_next = {16'h0000, segment_length - EXIF_LEN_MIN};
            phase_next = (segment_length == EXIF_LEN_MIN) ? PH_MARKER : PH_SKIPSEG;
            field_byte_index_next = '0; assembly_next = '0;
          end
        end
        PH_ORDER: begin
          if (field_byte_index == 4'd0) begin
            field_byte_index_next = 4'd1;
          end else if (asm_sh == ORDER_II || asm_sh == ORDER_MM) begin
            little_endian_next = (asm_sh == ORDER_II);
            phase_next = PH_MAGIC; field_byte_index_next = '0; assembly_next = '0;
          end else begin
            emit = 1'b1;
          end
        end
        PH_MAGIC: begin
          if (field_byte_index == 4'd0) begin
            field_byte_index_next = 4'd1;
          end else if (o16 != TIFF_MAGIC) begin
            emit = 1'b1;
          end else begin
            phase_next = PH_OFFSET; field_byte_index_next = '0; assembly_next = '0;
          end
        end
        PH_OFFSET: begin
          if (field_byte_index < OFFSET_LAST) begin
            field_byte_index_next = field_byte_index + 4'd1;
          end else if (off32 < IFD_OFS_MIN) begin
            emit = 1'b1;
          end else begin
            skip_remaining_next = off32 - IFD_OFS_MIN;
            phase_next = (off32 == IFD_OFS_MIN) ? PH_COUNT : PH_SKIPIFD;
            field_byte_index_next = '0; assembly_next = '0;
          end
        end
        PH_SKIPIFD: begin
          skip_remaining_next = skip_dec;
          if (skip_dec == '0) begin
            phase_next = PH_COUNT; field_byte_index_next = '0; assembly_next = '0;
          end
        end
        PH_COUNT: begin
          if (field_byte_index == 4'd0) begin
            field_byte_index_next = 4'd1;
          end else begin
            entries_left_next = o16;
            if (o16 == '0) begin
              emit = 1'b1;
            end else begin
              phase_next = PH_ENTRY; field_byte_index_next = '0; assembly_next = '0;
            end
          end
        end
        PH_ENTRY: begin
          if (field_byte_index == ENTRY_TAG_IDX) current_tag_next = o16;
          if (field_byte_index == ENTRY_VAL_IDX && current_tag == target_tag) begin
            emit = 1'b1; emit_value = o16; emit_found = 1'b1;
          end else if (field_byte_index < ENTRY_LAST) begin
            field_byte_index_next = field_byte_index + 4'd1;
          end else begin
            entries_left_next = entries_left - 16'd1;
            if (entries_left == 16'd1) begin
              emit = 1'b1;
            end else begin
              phase_next = PH_ENTRY; field_byte_index_next = '0; assembly_next = '0;
            end
          end
        end
        default: begin
        end
      endcase

      if (emit) begin
        phase_next        = PH_DONE;
        result_given_next = 1'b1;
      end
    end

    if (step) begin
      // either the byte produced a result, or end of file forces the default
      if (!result_given && (emit || item.last)) begin
        res.valid = 1'b1;
        res.value = emit ? emit_value : default_value;
        res.found = emit && emit_found;
      end
      if (item.last) begin
        phase_next            = PH_SOI;
        field_byte_index_next = '0;
        assembly_next         = '0;
        skip_remaining_next   = '0;
        segment_length_next   = '0;
        little_endian_next    = 1'b0;
        entries_left_next     = '0;
        current_tag_next      = '0;
        result_given_next     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SOI;
      field_byte_index <= '0;
      assembly         <= '0;
      skip_remaining   <= '0;
      segment_length   <= '0;
      little_endian    <= 1'b0;
      entries_left     <= '0;
      current_tag      <= '0;
      result_given     <= 1'b0;
    end else begin
      phase            <= phase_next;
      field_byte_index <= field_byte_index_next;
      assembly         <= assembly_next;
      skip_remaining   <= skip_remaining_next;
      segment_length   <= segment_length_next;
      little_endian    <= little_endian_next;
      entries_left     <= entries_left_next;
      current_tag      <= current_tag_next;
      result_given     <= result_given_next;
    end
  end

endmodule

// ===== design/jpeg_exif_orientation_parser_top.sv =====
// Top level: JPEG Exif IFD0 tag parser with byte input channel and result output channel.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready, data_byte, last_byte) carries the file one byte
//   per transfer; last_byte marks the final byte and rearms the parser for the next file.
//   Output channel (out_valid/out_ready, tag_value, found) carries one result per file:
//   the target tag's value with found set, or default_value with found clear when the
//   file is malformed, ends early, or IFD0 lacks the tag. Bytes after a result are dropped.
//   Configuration (cfg_wr_en, cfg_index, cfg_data) writes target_tag (index 0) and
//   default_value (index 1); write only while no file is in flight.
// Timing:
//   One byte per cycle sustained while the output is not stalled. A byte enters the input
//   register at its transfer edge; the parser updates its state from that register and
//   loads any result into the output register when it advances the byte, which waits while
//   a result is stalled on out_ready. The parse state update is the single per-byte step.
// Reset:
//   rst (synchronous) empties both registers, returns the parser to expecting start of
//   image and restores target_tag = 0x0112 and default_value = 1.
// Stall:
//   While a result waits on out_ready, the input register still takes one byte; in_ready
//   drops only when that byte is held and the output register is full.
module jpeg_exif_orientation_parser_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] tag_value,
  output logic        found,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import jeop_pkg::*;

  logic [15:0] target_tag;
  logic [15:0] default_value;
  item_t       item_in;
  item_t       item_q;
  logic        item_valid;
  logic        advance;
  result_t     res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_tag    <= TARGET_TAG_RESET;
      default_value <= DEFAULT_VALUE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TARGET_TAG:    target_tag    <= cfg_data;
        CFG_DEFAULT_VALUE: default_value <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign item_in.data = data_byte;
  assign item_in.last = last_byte;

  // Advance the held byte whenever the output register can take a result
  assign advance = item_valid && (!out_valid || out_ready);

  jeop_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .item_in    (item_in),
    .advance    (advance),
    .item_valid (item_valid),
    .item_q     (item_q)
  );

  jeop_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item_q),
    .target_tag    (target_tag),
    .default_value (default_value),
    .res           (res)
  );

  // Output register: load on a new result, drop once the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      tag_value <= res.value;
      found     <= res.found;
    end
  end

endmodule

// ===== design/jeop_checker.sv =====
// Checker: port-level properties of the Exif tag parser, bound to the top level.
`timescale 1ns / 1ps
module jeop_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] tag_value,
  input logic        found
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(tag_value) && $stable(found))
    else $error("result changed while stalled");

  // input backpressure only while the output is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("in_ready low without output stall");

  // a fresh result is preceded by a byte transfer into the input register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching byte transfer");

  // reset leaves both registers empty
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("registers not empty after reset");

endmodule

bind jpeg_exif_orientation_parser_top jeop_checker u_jeop_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .tag_value (tag_value),
  .found     (found)
);
